// File: rtl/assert_macros.svh
// Assertion helpers for the RTL, included by delta_sleep_queue.
// Each macro takes a label, the clock, the active-low reset, the check and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant, checked at every clock edge outside reset.
`define DSQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Same-cycle implication.
`define DSQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define DSQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/dsq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsq_pkg
// Types and constants shared by the delta sleep queue modules.
// ----------------------------------------------------------------------------
package dsq_pkg;

	// Field widths of one item
	localparam int ID_W        = 8;
	localparam int TIME_W      = 16;
	localparam int OPCODE_W    = 2;

	// Wake releases at most this many threads per item
	localparam int MAX_RESULTS = 16;
	localparam int NW          = $clog2(MAX_RESULTS + 1);

	typedef enum logic [OPCODE_W-1:0] {
		OP_INSERT = 2'd0,
		OP_TICK   = 2'd1,
		OP_WAKE   = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WALK,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_SUCC,
		ST_PLACE,
		ST_STATUS,
		ST_POP,
		ST_POP_LD,
		ST_REL_RD,
		ST_REL_OUT
	} state_t;

	// One list entry: thread handle and delta to the entry ahead
	typedef struct packed {
		logic [ID_W-1:0]   thread;
		logic [TIME_W-1:0] delta;
	} entry_t;

	// Result of the shared subtractor
	typedef struct packed {
		logic              borrow;
		logic [TIME_W-1:0] diff;
	} sub_res_t;

endpackage
`default_nettype wire

// File: rtl/dsq_sub.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsq_sub
// Shared subtract and compare unit: diff = a - b, borrow set when a < b.
// ----------------------------------------------------------------------------
module dsq_sub import dsq_pkg::*; (
	input  wire logic [TIME_W-1:0] a,
	input  wire logic [TIME_W-1:0] b,
	output sub_res_t               res
);

	logic [TIME_W:0] wide;

	// Subtract with one extra bit to catch the borrow
	assign wide       = {1'b0, a} - {1'b0, b};
	assign res.borrow = wide[TIME_W];
	assign res.diff   = wide[TIME_W-1:0];

endmodule
`default_nettype wire

// File: rtl/dsq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsq_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dsq_ram import dsq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire entry_t                   wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output entry_t                        rdata
);

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	// Write the addressed entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read every cycle into registered read data
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: rtl/delta_sleep_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// delta_sleep_queue
// Sleep queue kept as a delta list in a circular entry store, driven by a
// small sequencer around one shared subtractor.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake             Fields
// cmd      in   cmd_valid, cmd_stall  opcode, thread_id, timeout
// rsp      out  rsp_valid, rsp_stall  released, woken_id, last, overflow,
//                                     queue_empty, head_remaining
//
// Tick, no-op and a full-queue insert give a status result. An insert walks
// the list and, unless it lands at the tail, shifts later entries toward the
// tail and updates the successor's delta, then places the new entry. A wake
// pops expired heads, then hands out each released thread as one result, or a
// status result if none expired. Reset clears the count, the head pointer and
// the sequencer; no clearing pass. A stalled result holds the sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module delta_sleep_queue import dsq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	output logic                     cmd_stall,
	input  wire logic [OPCODE_W-1:0] opcode,
	input  wire logic [ID_W-1:0]     thread_id,
	input  wire logic [TIME_W-1:0]   timeout,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output logic                     released,
	output logic [ID_W-1:0]          woken_id,
	output logic                     last,
	output logic                     overflow,
	output logic                     queue_empty,
	output logic [TIME_W-1:0]        head_remaining
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = $clog2(DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);

	// Logical list position to store address, wrapping at DEPTH
	function automatic logic [PW-1:0] phys(input logic [PW-1:0] base,
		input logic [CW-1:0] x);
		logic [CW:0] s;
		s = (CW + 1)'(base) + (CW + 1)'(x);
		if (s >= DEPTH_S) begin
			s = s - DEPTH_S;
		end
		return s[PW-1:0];
	endfunction

	state_t            state_q, state_d;
	logic [CW-1:0]     count_q, count_d;
	logic [PW-1:0]     head_q, head_d;
	logic [PW-1:0]     start_q, start_d;
	logic [TIME_W-1:0] hd_q, hd_d;
	logic [TIME_W-1:0] t_q, t_d;
	logic [ID_W-1:0]   id_q, id_d;
	logic [CW-1:0]     k_q, k_d;
	logic [CW-1:0]     pos_q, pos_d;
	logic [CW-1:0]     j_q, j_d;
	logic [ID_W-1:0]   succ_id_q, succ_id_d;
	logic [TIME_W-1:0] succ_dl_q, succ_dl_d;
	logic [NW-1:0]     n_q, n_d;
	logic [NW-1:0]     rk_q, rk_d;
	logic              ovf_q, ovf_d;

	logic              rsp_valid_q, rsp_valid_d;
	logic              released_q, released_d;
	logic [ID_W-1:0]   woken_id_q, woken_id_d;
	logic              last_q, last_d;
	logic              overflow_q, overflow_d;
	logic              queue_empty_q, queue_empty_d;
	logic [TIME_W-1:0] head_rem_q, head_rem_d;

	logic              ram_we;
	logic [CW-1:0]     wr_x;
	entry_t            ram_wdata;
	logic [PW-1:0]     rd_base;
	logic [CW-1:0]     rd_x;
	logic [PW-1:0]     ram_raddr;
	logic [PW-1:0]     ram_waddr;
	entry_t            ram_rdata;

	logic [TIME_W-1:0] sub_a, sub_b;
	sub_res_t          sub_res;

	logic [TIME_W-1:0] walk_dl;
	logic [CW-1:0]     k_inc, j_dec, pos_inc;
	logic              out_free;
	logic              pop_go;
	logic              rel_last;

	dsq_ram #(
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	dsq_sub u_sub (
		.a   (sub_a),
		.b   (sub_b),
		.res (sub_res)
	);

	// Address and helper terms
	assign ram_raddr = phys(rd_base, rd_x);
	assign ram_waddr = phys(head_q, wr_x);
	assign walk_dl   = (k_q == '0) ? hd_q : ram_rdata.delta;
	assign k_inc     = k_q + CW'(1);
	assign j_dec     = j_q - CW'(1);
	assign pos_inc   = pos_q + CW'(1);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign pop_go    = (state_q == ST_POP) && (n_q < NW'(MAX_RESULTS)) &&
		(count_q != '0) && (hd_q == '0);
	assign rel_last  = (rk_q + NW'(1)) == n_q;

	// Sequencer: next state and datapath control
	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		head_d        = head_q;
		start_d       = start_q;
		hd_d          = hd_q;
		t_d           = t_q;
		id_d          = id_q;
		k_d           = k_q;
		pos_d         = pos_q;
		j_d           = j_q;
		succ_id_d     = succ_id_q;
		succ_dl_d     = succ_dl_q;
		n_d           = n_q;
		rk_d          = rk_q;
		ovf_d         = ovf_q;
		rsp_valid_d   = rsp_valid_q && rsp_stall;
		released_d    = released_q;
		woken_id_d    = woken_id_q;
		last_d        = last_q;
		overflow_d    = overflow_q;
		queue_empty_d = queue_empty_q;
		head_rem_d    = head_rem_q;
		ram_we        = 1'b0;
		wr_x          = pos_q;
		ram_wdata     = '{thread: id_q, delta: t_q};
		rd_base       = head_q;
		rd_x          = '0;
		sub_a         = t_q;
		sub_b         = walk_dl;

		unique case (state_q)
			ST_IDLE: begin
				// Read the head entry ahead of a possible walk
				rd_x = '0;
				if (cmd_valid) begin
					ovf_d = 1'b0;
					unique case (op_t'(opcode))
						OP_INSERT: begin
							if (count_q == DEPTH_C) begin
								ovf_d   = 1'b1;
								state_d = ST_STATUS;
							end else begin
								t_d     = timeout;
								id_d    = thread_id;
								k_d     = '0;
								state_d = ST_WALK;
							end
						end
						OP_TICK: begin
							sub_a = hd_q;
							sub_b = TIME_W'(1);
							if (count_q != '0 && hd_q != '0) begin
								hd_d = sub_res.diff;
							end
							state_d = ST_STATUS;
						end
						OP_WAKE: begin
							n_d     = '0;
							start_d = head_q;
							state_d = ST_POP;
						end
						OP_NOP: begin
							state_d = ST_STATUS;
						end
						default: begin
							state_d = ST_STATUS;
						end
					endcase
				end
			end
			ST_WALK: begin
				// Subtract deltas until the timeout falls short
				rd_x  = k_inc;
				sub_a = t_q;
				sub_b = walk_dl;
				if (k_q == count_q) begin
					pos_d   = k_q;
					state_d = ST_PLACE;
				end else if (!sub_res.borrow) begin
					t_d = sub_res.diff;
					k_d = k_inc;
				end else begin
					pos_d     = k_q;
					succ_id_d = ram_rdata.thread;
					succ_dl_d = walk_dl;
					j_d       = count_q;
					state_d   = (count_q > k_inc) ? ST_SHIFT_RD : ST_SUCC;
				end
			end
			ST_SHIFT_RD: begin
				rd_x    = j_dec;
				state_d = ST_SHIFT_WR;
			end
			ST_SHIFT_WR: begin
				// Move one entry toward the tail
				rd_x      = j_dec;
				ram_we    = 1'b1;
				wr_x      = j_q;
				ram_wdata = ram_rdata;
				j_d       = j_dec;
				state_d   = (j_dec > pos_inc) ? ST_SHIFT_RD : ST_SUCC;
			end
			ST_SUCC: begin
				// Take the remainder off the successor's delta
				sub_a     = succ_dl_q;
				sub_b     = t_q;
				ram_we    = 1'b1;
				wr_x      = pos_inc;
				ram_wdata = '{thread: succ_id_q, delta: sub_res.diff};
				state_d   = ST_PLACE;
			end
			ST_PLACE: begin
				// Store the new entry and grow the list
				ram_we    = 1'b1;
				wr_x      = pos_q;
				ram_wdata = '{thread: id_q, delta: t_q};
				count_d   = count_q + CW'(1);
				if (pos_q == '0) begin
					hd_d = t_q;
				end
				state_d = ST_STATUS;
			end
			ST_STATUS: begin
				if (out_free) begin
					rsp_valid_d   = 1'b1;
					released_d    = 1'b0;
					woken_id_d    = '0;
					last_d        = 1'b1;
					overflow_d    = ovf_q;
					queue_empty_d = (count_q == '0);
					head_rem_d    = (count_q != '0) ? hd_q : '0;
					state_d       = ST_IDLE;
				end
			end
			ST_POP: begin
				// Drop an expired head and fetch the next head delta
				rd_x = CW'(1);
				if (pop_go) begin
					head_d  = ram_raddr;
					count_d = count_q - CW'(1);
					n_d     = n_q + NW'(1);
					state_d = ST_POP_LD;
				end else if (n_q == '0) begin
					state_d = ST_STATUS;
				end else begin
					rk_d    = '0;
					state_d = ST_REL_RD;
				end
			end
			ST_POP_LD: begin
				hd_d    = ram_rdata.delta;
				state_d = ST_POP;
			end
			ST_REL_RD: begin
				rd_base = start_q;
				rd_x    = CW'(rk_q);
				state_d = ST_REL_OUT;
			end
			ST_REL_OUT: begin
				// Hand out one released thread per result
				rd_base = start_q;
				rd_x    = CW'(rk_q);
				if (out_free) begin
					rsp_valid_d   = 1'b1;
					released_d    = 1'b1;
					woken_id_d    = ram_rdata.thread;
					last_d        = rel_last;
					overflow_d    = 1'b0;
					queue_empty_d = (count_q == '0);
					head_rem_d    = (count_q != '0) ? hd_q : '0;
					if (rel_last) begin
						state_d = ST_IDLE;
					end else begin
						rk_d    = rk_q + NW'(1);
						state_d = ST_REL_RD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			head_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			head_q      <= head_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	// Datapath and result registers
	always_ff @(posedge clk) begin
		start_q       <= start_d;
		hd_q          <= hd_d;
		t_q           <= t_d;
		id_q          <= id_d;
		k_q           <= k_d;
		pos_q         <= pos_d;
		j_q           <= j_d;
		succ_id_q     <= succ_id_d;
		succ_dl_q     <= succ_dl_d;
		n_q           <= n_d;
		rk_q          <= rk_d;
		ovf_q         <= ovf_d;
		released_q    <= released_d;
		woken_id_q    <= woken_id_d;
		last_q        <= last_d;
		overflow_q    <= overflow_d;
		queue_empty_q <= queue_empty_d;
		head_rem_q    <= head_rem_d;
	end

	assign cmd_stall      = (state_q != ST_IDLE);
	assign rsp_valid      = rsp_valid_q;
	assign released       = released_q;
	assign woken_id       = woken_id_q;
	assign last           = last_q;
	assign overflow       = overflow_q;
	assign queue_empty    = queue_empty_q;
	assign head_remaining = head_rem_q;

	// Checks
	`DSQ_ASSERT(a_count_max, clk, arst_n, count_q <= DEPTH_C, "entry count above depth")
	`DSQ_ASSERT_NXT(a_full_drop, clk, arst_n,
		(state_q == ST_IDLE) && cmd_valid && (opcode == OP_INSERT) && (count_q == DEPTH_C),
		$stable(count_q) && (state_q == ST_STATUS) && ovf_q, "full insert not dropped")
	`DSQ_ASSERT_NXT(a_pop_count, clk, arst_n, pop_go,
		(count_q == $past(count_q) - CW'(1)) && (n_q == $past(n_q) + NW'(1)),
		"pop did not shrink the list")
	`DSQ_ASSERT_IMP(a_rel_nonzero, clk, arst_n, state_q == ST_REL_OUT,
		(n_q != '0) && (rk_q < n_q), "release readout out of range")

endmodule
`default_nettype wire

// File: bench/tb_delta_sleep_queue.sv
// ----------------------------------------------------------------------------
// tb_delta_sleep_queue
// Self-checking bench for the delta-list sleep queue. A short table of
// directed items (empty queue, extreme handles and timeouts, ties, a full
// queue, a wake that drains many threads) is followed by random phases of
// insert, tick, wake and no-op items. A shadow delta list predicts every
// result, and each result taken from the block is compared field by field.
// Both channels idle in random bursts; once the receiver holds off for a
// long stretch so the block backs up.
// ----------------------------------------------------------------------------
module tb_delta_sleep_queue;
	timeunit 1ns;
	timeprecision 1ps;
	import dsq_pkg::*;

	localparam int QDEPTH      = 16;
	localparam int HOLD_CYCLES = 600;
	localparam int DRAIN_WAIT  = 200;
	localparam int PHASE_ITEMS = 82;

	// One result of the block
	typedef struct packed {
		logic              released;
		logic [ID_W-1:0]   woken_id;
		logic              last;
		logic              overflow;
		logic              queue_empty;
		logic [TIME_W-1:0] head_remaining;
	} wake_result_t;

	// One row of the directed table
	typedef struct {
		op_t               op;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] ticks;
		bit                typed;
		wake_result_t      want;
	} script_row_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                cmd_valid = 1'b0;
	logic                cmd_stall;
	logic [OPCODE_W-1:0] opcode = OP_NOP;
	logic [ID_W-1:0]     thread_id = '0;
	logic [TIME_W-1:0]   timeout = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	logic                released;
	logic [ID_W-1:0]     woken_id;
	logic                last;
	logic                overflow;
	logic                queue_empty;
	logic [TIME_W-1:0]   head_remaining;

	// Shadow delta list
	logic [ID_W-1:0]   shadow_thread [QDEPTH];
	logic [TIME_W-1:0] shadow_delta  [QDEPTH];
	int                shadow_count;

	wake_result_t expected_results[$];
	script_row_t  script[$];

	bit gaps_on = 1'b1;
	bit idle_en = 1'b1;
	bit long_hold = 1'b0;
	int stall_left = 0;

	int items_taken = 0;
	int mismatches = 0;
	int results_seen = 0;
	int n_insert = 0;
	int n_tick = 0;
	int n_wake = 0;
	int n_nop = 0;
	int n_dropped = 0;
	int n_woken = 0;
	int most_woken = 0;

	delta_sleep_queue #(.DEPTH(QDEPTH)) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_stall      (cmd_stall),
		.opcode         (opcode),
		.thread_id      (thread_id),
		.timeout        (timeout),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.released       (released),
		.woken_id       (woken_id),
		.last           (last),
		.overflow       (overflow),
		.queue_empty    (queue_empty),
		.head_remaining (head_remaining)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Build a result from the shadow list as it stands after the operation
	function automatic wake_result_t list_status(logic rel, logic [ID_W-1:0] id,
			logic lst, logic ovf);
		wake_result_t r;
		r.released       = rel;
		r.woken_id       = id;
		r.last           = lst;
		r.overflow       = ovf;
		r.queue_empty    = (shadow_count == 0);
		r.head_remaining = (shadow_count != 0) ? shadow_delta[0] : '0;
		return r;
	endfunction

	// Apply one accepted item to the shadow list and queue its results
	function automatic void apply_sleep_op(op_t op, logic [ID_W-1:0] id,
			logic [TIME_W-1:0] ticks);
		logic [TIME_W-1:0] rem;
		logic [ID_W-1:0]   woke [MAX_RESULTS];
		int                pos;
		int                n;
		int                j;
		rem = ticks;
		pos = 0;
		n = 0;
		case (op)
			OP_INSERT: begin
				n_insert++;
				if (shadow_count >= QDEPTH) begin
					n_dropped++;
					expected_results.push_back(list_status(1'b0, '0, 1'b1, 1'b1));
				end else begin
					// walk past every delta the timeout reaches
					while (pos < shadow_count && rem >= shadow_delta[pos]) begin
						rem = rem - shadow_delta[pos];
						pos++;
					end
					for (j = shadow_count; j > pos; j--) begin
						shadow_thread[j] = shadow_thread[j-1];
						shadow_delta[j]  = shadow_delta[j-1];
					end
					shadow_thread[pos] = id;
					shadow_delta[pos]  = rem;
					shadow_count++;
					if (pos + 1 < shadow_count)
						shadow_delta[pos+1] = shadow_delta[pos+1] - rem;
					expected_results.push_back(list_status(1'b0, '0, 1'b1, 1'b0));
				end
			end
			OP_TICK: begin
				n_tick++;
				if (shadow_count > 0 && shadow_delta[0] != 0)
					shadow_delta[0] = shadow_delta[0] - 1'b1;
				expected_results.push_back(list_status(1'b0, '0, 1'b1, 1'b0));
			end
			OP_WAKE: begin
				n_wake++;
				// pop expired heads, up to the per-item release limit
				while (n < MAX_RESULTS && shadow_count > 0 && shadow_delta[0] == 0) begin
					woke[n] = shadow_thread[0];
					for (j = 1; j < shadow_count; j++) begin
						shadow_thread[j-1] = shadow_thread[j];
						shadow_delta[j-1]  = shadow_delta[j];
					end
					shadow_count--;
					n++;
				end
				if (n == 0)
					expected_results.push_back(list_status(1'b0, '0, 1'b1, 1'b0));
				for (j = 0; j < n; j++)
					expected_results.push_back(list_status(1'b1, woke[j], j == n - 1, 1'b0));
				n_woken += n;
				if (n > most_woken)
					most_woken = n;
			end
			default: begin
				n_nop++;
				expected_results.push_back(list_status(1'b0, '0, 1'b1, 1'b0));
			end
		endcase
	endfunction

	// Offer one item, hold it until taken, then predict its results
	task automatic offer_item(op_t op, logic [ID_W-1:0] id, logic [TIME_W-1:0] ticks);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		opcode    <= op;
		thread_id <= id;
		timeout   <= ticks;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		items_taken++;
		apply_sleep_op(op, id, ticks);
	endtask

	function automatic void add_row(op_t op, logic [ID_W-1:0] id,
			logic [TIME_W-1:0] ticks, bit typed, wake_result_t want);
		script_row_t row;
		row.op    = op;
		row.id    = id;
		row.ticks = ticks;
		row.typed = typed;
		row.want  = want;
		script.push_back(row);
	endfunction

	// Receiver stall: random bursts, plus the long hold-off
	always @(posedge clk) begin
		logic stall_now;
		stall_now = 1'b0;
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			stall_now = 1'b1;
		end else if (idle_en && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 18);
			stall_now = 1'b1;
		end
		rsp_stall <= stall_now || long_hold;
	end

	// Long hold-off once the random part is under way
	initial begin
		wait (items_taken >= 45);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	// Compare each taken result with the oldest expectation
	always @(posedge clk) begin
		wake_result_t got;
		wake_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			got = '{released, woken_id, last, overflow, queue_empty, head_remaining};
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: rel=%0d id=%02h last=%0d ovf=%0d empty=%0d head=%04h",
						got.released, got.woken_id, got.last, got.overflow,
						got.queue_empty, got.head_remaining);
			end else begin
				want = expected_results.pop_front();
				if (got.released !== want.released || got.woken_id !== want.woken_id ||
						got.last !== want.last || got.overflow !== want.overflow ||
						got.queue_empty !== want.queue_empty ||
						got.head_remaining !== want.head_remaining) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch on result %0d:", results_seen);
						$display("  exp rel=%0d id=%02h last=%0d ovf=%0d empty=%0d head=%04h",
							want.released, want.woken_id, want.last, want.overflow,
							want.queue_empty, want.head_remaining);
						$display("  got rel=%0d id=%02h last=%0d ovf=%0d empty=%0d head=%04h",
							got.released, got.woken_id, got.last, got.overflow,
							got.queue_empty, got.head_remaining);
					end
				end
			end
		end
	end

	// Watchdog
	initial begin
		#8_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		wake_result_t      idle_empty;
		wake_result_t      full_drop;
		op_t               op;
		logic [TIME_W-1:0] ticks;
		int                w_ins;
		int                w_tick;
		int                w_wake;
		int                r;
		int                s;
		int                ph;
		int                i;
		idle_empty = '{1'b0, '0, 1'b1, 1'b0, 1'b1, '0};
		full_drop  = '{1'b0, '0, 1'b1, 1'b1, 1'b0, '0};

		// Directed table: empty queue, extremes, ties, full queue, big wake
		add_row(OP_WAKE,   8'h00, 16'h0000, 1'b1, idle_empty);
		add_row(OP_TICK,   8'h00, 16'h0000, 1'b1, idle_empty);
		add_row(OP_NOP,    8'h00, 16'h0000, 1'b1, idle_empty);
		add_row(OP_INSERT, 8'hFF, 16'hFFFF, 1'b1, '{1'b0, '0, 1'b1, 1'b0, 1'b0, 16'hFFFF});
		add_row(OP_INSERT, 8'h00, 16'h0000, 1'b1, '{1'b0, '0, 1'b1, 1'b0, 1'b0, 16'h0000});
		add_row(OP_INSERT, 8'h01, 16'h0000, 1'b1, '{1'b0, '0, 1'b1, 1'b0, 1'b0, 16'h0000});
		add_row(OP_INSERT, 8'hAA, 16'h1234, 1'b0, '0);
		add_row(OP_TICK,   8'h00, 16'h0000, 1'b1, '{1'b0, '0, 1'b1, 1'b0, 1'b0, 16'h0000});
		add_row(OP_WAKE,   8'h00, 16'h0000, 1'b0, '0);
		for (i = 0; i < QDEPTH - 2; i++)
			add_row(OP_INSERT, ID_W'(i * 17 + 3), TIME_W'(0), 1'b0, '0);
		add_row(OP_INSERT, 8'h5A, 16'h8000, 1'b1, full_drop);
		add_row(OP_WAKE,   8'h00, 16'h0000, 1'b0, '0);

		shadow_count = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the table; typed rows stand in for the predicted result
		foreach (script[k]) begin
			offer_item(script[k].op, script[k].id, script[k].ticks);
			if (script[k].typed) begin
				void'(expected_results.pop_back());
				expected_results.push_back(script[k].want);
			end
		end

		// Random phases: fill, steady without idling, drain, quiet tail
		for (ph = 0; ph < 4; ph++) begin
			gaps_on = (ph == 0 || ph == 2);
			idle_en <= (ph == 0 || ph == 2);
			case (ph)
				0: begin w_ins = 50; w_tick = 25; w_wake = 20; end
				2: begin w_ins = 25; w_tick = 40; w_wake = 30; end
				default: begin w_ins = 35; w_tick = 35; w_wake = 25; end
			endcase
			for (i = 0; i < PHASE_ITEMS; i++) begin
				r = $urandom_range(0, 99);
				if (r < w_ins)
					op = OP_INSERT;
				else if (r < w_ins + w_tick)
					op = OP_TICK;
				else if (r < w_ins + w_tick + w_wake)
					op = OP_WAKE;
				else
					op = OP_NOP;
				// mostly short sleeps so threads expire; a few huge ones
				s = $urandom_range(0, 99);
				if (s < 70)
					ticks = TIME_W'($urandom_range(0, 6));
				else if (s < 97)
					ticks = TIME_W'($urandom_range(0, 40));
				else if (s < 99)
					ticks = TIME_W'($urandom);
				else
					ticks = '1;
				offer_item(op, ID_W'($urandom_range(0, 255)), ticks);
			end
		end
		cmd_valid <= 1'b0;

		// Drain, then let any stray result show up
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("items: %0d insert (%0d dropped on full), %0d tick, %0d wake, %0d no-op",
			n_insert, n_dropped, n_tick, n_wake, n_nop);
		$display("results: %0d taken, %0d threads woken, up to %0d in one wake, %0d mismatches",
			results_seen, n_woken, most_woken, mismatches);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
